### src/nfsa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfsa_pkg: shared types and constants of the next-fit slot allocator
// Field widths, command and status codes, and the controller/datapath links.
// ----------------------------------------------------------------------------
package nfsa_pkg;

  localparam int CMD_W     = 2;
  localparam int IDX_W     = 6;
  localparam int PAYLOAD_W = 64;
  localparam int STATUS_W  = 3;
  localparam int COUNT_W   = 7;

  // The bitmap is scanned one group of slots per cycle.
  localparam int GSIZE = 8;
  localparam int OFF_W = 3;

  localparam logic [COUNT_W-1:0] CAP_RESET = 7'd10;

  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEL   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

  localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DELETED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NONE    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_COUNT   = 3'd4;

  typedef struct packed {
    logic load;            // capture the accepted item
    logic exec_push;       // finish a delete or query and load the output register
    logic scan_init_ptr;   // start a search at the next-fit pointer
    logic scan_init_next;  // start a search just past the slot just written
    logic scan_step;       // advance the search by one group
    logic add_commit;      // write the found slot, mark it, count it
    logic ptr_from_scan;   // move the pointer to the found slot
    logic res_fail;        // record a rejected add
    logic fin_push;        // load the output register with the add result
  } dp_cmd_t;

  typedef struct packed {
    logic is_add;     // captured command is an add
    logic free_zero;  // no free capacity
    logic one_left;   // exactly one free slot of capacity
    logic hit;        // search found an unfilled slot in this group
    logic last;       // search is on its final group visit
  } dp_stat_t;

endpackage

`default_nettype wire

### src/nfsa_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfsa_in_if: command channel of the slot allocator
// Valid/ready channel carrying one command, slot index and payload word.
// ----------------------------------------------------------------------------
interface nfsa_in_if
  import nfsa_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     cmd;
  logic [IDX_W-1:0]     slot_index;
  logic [PAYLOAD_W-1:0] payload;

  modport source (output valid, cmd, slot_index, payload, input ready);
  modport sink   (input valid, cmd, slot_index, payload, output ready);
endinterface

`default_nettype wire

### src/nfsa_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfsa_out_if: result channel of the slot allocator
// Valid/ready channel carrying status, slot used and free count.
// ----------------------------------------------------------------------------
interface nfsa_out_if
  import nfsa_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0]    slot_used;
  logic [COUNT_W-1:0]  free_count;

  modport source (output valid, status, slot_used, free_count, input ready);
  modport sink   (input valid, status, slot_used, free_count, output ready);
endinterface

`default_nettype wire

### src/nfsa_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfsa_ram: generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module nfsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;
endmodule

`default_nettype wire

### src/nfsa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfsa_ctrl: sequencer of the slot allocator
// Steps each command through execution and the free-slot searches, and owns
// the input ready and the output valid.
// ----------------------------------------------------------------------------
module nfsa_ctrl
  import nfsa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire dp_stat_t dp_stat,
  output dp_cmd_t       dp_cmd
);
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_SCAN1 = 5'b00100,
    S_SCAN2 = 5'b01000,
    S_FIN   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    dp_cmd    = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dp_cmd.load = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (dp_stat.is_add) begin
          if (dp_stat.free_zero) begin
            dp_cmd.res_fail = 1'b1;
            state_nxt       = S_FIN;
          end else begin
            dp_cmd.scan_init_ptr = 1'b1;
            state_nxt            = S_SCAN1;
          end
        end else if (out_free) begin
          dp_cmd.exec_push = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      S_SCAN1: begin
        dp_cmd.scan_step = 1'b1;
        if (dp_stat.hit) begin
          dp_cmd.add_commit = 1'b1;
          if (dp_stat.one_left) begin
            state_nxt = S_FIN;
          end else begin
            dp_cmd.scan_init_next = 1'b1;
            state_nxt             = S_SCAN2;
          end
        end else if (dp_stat.last) begin
          dp_cmd.res_fail = 1'b1;
          state_nxt       = S_FIN;
        end
      end
      S_SCAN2: begin
        dp_cmd.scan_step = 1'b1;
        if (dp_stat.hit) begin
          dp_cmd.ptr_from_scan = 1'b1;
          state_nxt            = S_FIN;
        end else if (dp_stat.last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          dp_cmd.fin_push = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (dp_cmd.exec_push || dp_cmd.fin_push) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Only one command is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("nfsa_ctrl: second command accepted while one is in flight");

  // A result appears only out of the execute or finish step.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_EXEC || $past(state_r) == S_FIN))
    else $error("nfsa_ctrl: result raised outside execute or finish");

  // A result is pushed only when the output register is free.
  a_no_push_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.fin_push || dp_cmd.exec_push) |-> out_free)
    else $error("nfsa_ctrl: result pushed over an untaken result");
endmodule

`default_nettype wire

### src/nfsa_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// nfsa_datapath: bitmap, pointer, counters and slot store of the allocator
// Holds the occupancy bitmap in groups, runs the group-at-a-time cyclic
// search for an unfilled slot, and keeps the output register.
// ----------------------------------------------------------------------------
module nfsa_datapath
  import nfsa_pkg::*;
#(
  parameter int SLOTS     = 64,
  parameter int WORD_BITS = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [CMD_W-1:0]     in_cmd,
  input  wire logic [IDX_W-1:0]     in_slot_index,
  input  wire logic [PAYLOAD_W-1:0] in_payload,
  input  wire logic                 cfg_we,
  input  wire logic [COUNT_W-1:0]   cfg_wdata,
  input  wire dp_cmd_t              dp_cmd,
  output dp_stat_t                  dp_stat,
  output logic [STATUS_W-1:0]       out_status,
  output logic [IDX_W-1:0]          out_slot_used,
  output logic [COUNT_W-1:0]        out_free_count
);
  localparam int NGROUPS = (SLOTS + GSIZE - 1) / GSIZE;
  localparam int GW      = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
  localparam int PW      = GW + OFF_W;
  localparam int CW      = $clog2(NGROUPS + 1);
  localparam int AW      = $clog2(SLOTS);

  // Captured command.
  logic [CMD_W-1:0]     cmd_r;
  logic [IDX_W-1:0]     idx_r;
  logic [WORD_BITS-1:0] word_r;

  // Allocator state.
  logic [GSIZE-1:0]   filled_r [NGROUPS];
  logic [COUNT_W-1:0] cap_r;
  logic [COUNT_W-1:0] occ_r;
  logic [PW-1:0]      ptr_r;

  // Search state.
  logic [GW-1:0]    sc_grp_r;
  logic [OFF_W-1:0] sc_off_r;
  logic [CW-1:0]    sc_cnt_r;

  // Add result and output register.
  logic [STATUS_W-1:0] res_status_r;
  logic [PW-1:0]       res_slot_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [IDX_W-1:0]    out_slot_r;
  logic [COUNT_W-1:0]  out_free_r;

  logic [COUNT_W-1:0] free_now;
  logic [COUNT_W-1:0] occ_out;
  logic [COUNT_W-1:0] free_out;
  logic [GSIZE-1:0]   cur_grp;
  logic [GSIZE-1:0]   free_bits;
  logic               sc_first;
  logic               sc_last;
  logic               hit;
  logic [OFF_W-1:0]   hit_j;
  logic [PW-1:0]      hit_idx;
  logic [PW-1:0]      start;
  logic [GW-1:0]      grp_inc;
  logic               del_ok;
  logic [PW-1:0]      del_pidx;
  logic               del_hit;
  logic               is_del;
  logic [STATUS_W-1:0] exec_status;
  logic [IDX_W-1:0]    exec_slot;

  function automatic logic [COUNT_W-1:0] free_of(input logic [COUNT_W-1:0] cap,
                                                 input logic [COUNT_W-1:0] occ);
    return (cap > occ) ? (cap - occ) : '0;
  endfunction

  assign free_now = free_of(cap_r, occ_r);

  // Delete lookup; an index past the last slot never hits.
  assign is_del   = (cmd_r == CMD_DEL);
  assign del_ok   = (32'(idx_r) < SLOTS);
  assign del_pidx = PW'(idx_r);
  assign del_hit  = del_ok && filled_r[del_pidx[PW-1:OFF_W]][del_pidx[OFF_W-1:0]];

  always_comb begin
    case (cmd_r)
      CMD_DEL: begin
        exec_status = del_hit ? ST_DELETED : ST_NONE;
        exec_slot   = idx_r;
      end
      default: begin
        exec_status = ST_COUNT;
        exec_slot   = '0;
      end
    endcase
  end

  // Search over one group: the first visit skips slots below the start
  // offset, the closing visit of the start group covers only those slots.
  assign cur_grp  = filled_r[sc_grp_r];
  assign sc_first = (sc_cnt_r == '0);
  assign sc_last  = (sc_cnt_r == CW'(NGROUPS));

  always_comb begin
    for (int j = 0; j < GSIZE; j++) begin
      free_bits[j] = !cur_grp[j]
                     && (((32'(sc_grp_r) << OFF_W) + 32'(j)) < SLOTS)
                     && (sc_first ? (OFF_W'(j) >= sc_off_r)
                                  : (sc_last ? (OFF_W'(j) < sc_off_r) : 1'b1));
    end
  end

  always_comb begin
    hit   = 1'b0;
    hit_j = '0;
    for (int j = GSIZE - 1; j >= 0; j--) begin
      if (free_bits[j]) begin
        hit   = 1'b1;
        hit_j = OFF_W'(j);
      end
    end
  end

  // The second search starts just past the slot that is being written in
  // this same cycle.
  assign hit_idx = {sc_grp_r, hit_j};
  assign grp_inc = (32'(sc_grp_r) == NGROUPS - 1) ? '0 : sc_grp_r + 1'b1;
  assign start   = dp_cmd.scan_init_next
                   ? ((32'(hit_idx) == SLOTS - 1) ? '0 : hit_idx + 1'b1)
                   : ptr_r;

  assign dp_stat.is_add    = (cmd_r == CMD_ADD);
  assign dp_stat.free_zero = (free_now == '0);
  assign dp_stat.one_left  = (free_now == COUNT_W'(1));
  assign dp_stat.hit       = hit;
  assign dp_stat.last      = sc_last;

  // The free count goes out after this item's own update.
  assign occ_out  = (dp_cmd.exec_push && is_del && del_hit && occ_r != '0)
                    ? occ_r - 1'b1 : occ_r;
  assign free_out = free_of(cap_r, occ_out);

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd_r  <= in_cmd;
      idx_r  <= in_slot_index;
      word_r <= in_payload[WORD_BITS-1:0];
    end
    if (dp_cmd.scan_init_ptr || dp_cmd.scan_init_next) begin
      sc_grp_r <= start[PW-1:OFF_W];
      sc_off_r <= start[OFF_W-1:0];
      sc_cnt_r <= '0;
    end else if (dp_cmd.scan_step) begin
      sc_grp_r <= grp_inc;
      sc_cnt_r <= sc_cnt_r + 1'b1;
    end
    if (dp_cmd.add_commit) begin
      res_status_r <= ST_ADDED;
      res_slot_r   <= hit_idx;
    end else if (dp_cmd.res_fail) begin
      res_status_r <= ST_FULL;
      res_slot_r   <= '0;
    end
    if (dp_cmd.exec_push) begin
      out_status_r <= exec_status;
      out_slot_r   <= exec_slot;
      out_free_r   <= free_out;
    end else if (dp_cmd.fin_push) begin
      out_status_r <= res_status_r;
      out_slot_r   <= IDX_W'(res_slot_r);
      out_free_r   <= free_out;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int g = 0; g < NGROUPS; g++) begin
        filled_r[g] <= '0;
      end
      cap_r <= CAP_RESET;
      occ_r <= '0;
      ptr_r <= '0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (dp_cmd.add_commit) begin
        filled_r[sc_grp_r][hit_j] <= 1'b1;
        occ_r                     <= occ_r + 1'b1;
        ptr_r                     <= hit_idx;
      end else if (dp_cmd.ptr_from_scan) begin
        ptr_r <= hit_idx;
      end else if (dp_cmd.exec_push && is_del && del_hit) begin
        filled_r[del_pidx[PW-1:OFF_W]][del_pidx[OFF_W-1:0]] <= 1'b0;
        occ_r                                               <= occ_out;
      end
    end
  end

  nfsa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (SLOTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (dp_cmd.add_commit),
    .wr_addr (AW'(hit_idx)),
    .wr_data (word_r),
    .rd_addr (AW'(hit_idx)),
    .rd_data ()
  );

  assign out_status     = out_status_r;
  assign out_slot_used  = out_slot_r;
  assign out_free_count = out_free_r;

  // A committed add leaves its slot marked filled.
  a_add_marks: assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.add_commit |=> filled_r[$past(sc_grp_r)][$past(hit_j)])
    else $error("nfsa_datapath: added slot not marked filled");

  // A delete of a filled slot gives back exactly one unit of capacity.
  a_del_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (dp_cmd.exec_push && is_del && del_hit) |=> (occ_r == $past(occ_r) - 7'd1))
    else $error("nfsa_datapath: delete did not decrement the occupied count");

  // The next-fit pointer always names a real slot.
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(ptr_r) < SLOTS))
    else $error("nfsa_datapath: pointer beyond the last slot");
endmodule

`default_nettype wire

### src/next_fit_slot_allocator_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// next_fit_slot_allocator_top: next-fit bitmap slot allocator
// Stores payload words in slots chosen by a next-fit pointer over an
// occupancy bitmap; deletes free slots; queries report the free count.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Contents
//  in_ch     in         valid/ready        cmd, slot_index, payload
//  out_ch    out        valid/ready        status, slot_used, free_count
//  cfg_*     in         write enable only  capacity
//
//  Delete and query go from transfer through execute to the result. An add
//  runs a free-slot search, visiting one 8-slot group of the bitmap per
//  cycle, then a second search that moves the pointer; the second is skipped
//  when the add uses the last unit of capacity.
//  Reset is synchronous, clears the bitmap, pointer and count, and sets the capacity to CAP_RESET.
//  One command is worked at a time; the next is taken while a result waits
//  in the output register, and holds before its own result until that frees.
// ----------------------------------------------------------------------------
module next_fit_slot_allocator_top
  import nfsa_pkg::*;
#(
  parameter int SLOTS     = 64,
  parameter int WORD_BITS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  nfsa_in_if.sink                 in_ch,
  nfsa_out_if.source              out_ch,
  input  wire logic               cfg_we,
  input  wire logic [COUNT_W-1:0] cfg_wdata
);
  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;
  logic     in_ready;
  logic     out_valid;

  nfsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .dp_stat   (dp_stat),
    .dp_cmd    (dp_cmd)
  );

  nfsa_datapath #(
    .SLOTS     (SLOTS),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_cmd         (in_ch.cmd),
    .in_slot_index  (in_ch.slot_index),
    .in_payload     (in_ch.payload),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .dp_cmd         (dp_cmd),
    .dp_stat        (dp_stat),
    .out_status     (out_ch.status),
    .out_slot_used  (out_ch.slot_used),
    .out_free_count (out_ch.free_count)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
endmodule

`default_nettype wire
